[rtl/encoder_speed_estimator_assert.svh]
// Assertion macros shared by the encoder speed estimator RTL.
`ifndef ENCODER_SPEED_ESTIMATOR_ASSERT_SVH
`define ENCODER_SPEED_ESTIMATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Clocked check that is switched off while reset is high.
`define ESE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also runs through reset.
`define ESE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ESE_ASSERT(label, clk, rst, prop, msg)
`define ESE_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[rtl/ese_pkg.sv]
// Types and constants of the encoder speed estimator.
`timescale 1ns / 1ps
package ese_pkg;

   // Register reset values.
   localparam logic [15:0] MIN_PERIOD_RST       = 16'd320;
   localparam logic [7:0]  STALL_TICKS_RST      = 8'd200;
   localparam logic [23:0] PERIOD_NUMERATOR_RST = 24'd960000;
   localparam logic [15:0] COUNT_GAIN_RST       = 16'd3000;

   localparam int NUM_CHANNELS_DEF = 4;

   // Divider: one quotient bit per cycle over the 24-bit numerator.
   localparam int DIV_STEPS = 24;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Configuration space.
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_MIN_PERIOD       = 2'd0;
   localparam logic [1:0] REG_STALL_TICKS      = 2'd1;
   localparam logic [1:0] REG_PERIOD_NUMERATOR = 2'd2;
   localparam logic [1:0] REG_COUNT_GAIN       = 2'd3;

   typedef struct packed {
      logic [1:0]  channel;
      logic [15:0] fwd_period;
      logic [15:0] rev_period;
      logic [15:0] position;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         out_channel;
      logic signed [31:0] speed;
      logic               clear_captures;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_WRITE
   } ese_state_type;

endpackage

[rtl/encoder_speed_estimator.sv]
// Encoder speed estimator: period method with count fallback, shared serial divider.
`timescale 1ns / 1ps
//
//   Channel   Ports                                   Direction   Moves
//   req       req_valid, req_stall, req_data          in          one tick sample
//   rsp       rsp_valid, rsp_stall, rsp_data          out         one speed result
//   csr       csr_psel ... csr_prdata, csr_pready     in/out      register access
//
// A tick that runs the divider is accepted, passes through the 24-step restoring
// divider (one quotient bit per cycle) and then loads the output register.
// A tick that falls back to the count method, or whose selected period is zero,
// goes from accept straight to the write state; a tick for a channel at or above
// NUM_CHANNELS is accepted without leaving the idle state and gives no result.
// Synchronous reset restores the register defaults and clears all channel state.
// A stalled result holds in the output register; the next tick may be accepted meanwhile,
// and the sequencer waits in its write state only while that register is still full and stalled.
module encoder_speed_estimator #(
   parameter int NUM_CHANNELS = ese_pkg::NUM_CHANNELS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  ese_pkg::req_payload_type          req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output ese_pkg::rsp_payload_type          rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ese_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import ese_pkg::*;

`include "encoder_speed_estimator_assert.svh"

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   // Configuration registers.
   logic [15:0] min_period_ff;
   logic [7:0]  stall_ticks_ff;
   logic [23:0] period_numerator_ff;
   logic [15:0] count_gain_ff;

   // Per-channel state.
   logic [15:0] last_pos_ff [NUM_CHANNELS];
   logic [7:0]  idle_cnt_ff [NUM_CHANNELS];

   // Sequencer and job registers.
   ese_state_type        state_ff, state_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [23:0]          num_ff, num_in;
   logic [15:0]          rem_ff, rem_in;
   logic [15:0]          divisor_ff, divisor_in;
   logic                 neg_ff, neg_in;
   logic                 use_div_ff, use_div_in;
   logic signed [31:0]   count_speed_ff, count_speed_in;
   logic [1:0]           job_channel_ff, job_channel_in;
   logic                 job_clear_ff, job_clear_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_data_ff, rsp_data_in;

   // Tick decode.
   logic [4:0]           ch_ext;
   logic                 ch_in_range;
   logic [IDX_W-1:0]     ch_idx;
   logic                 tick_take;
   logic                 tick_update;
   logic [15:0]          pos_delta;
   logic [7:0]           idle_inc;
   logic [7:0]           idle_cnt_in;
   logic                 tick_clear;
   logic signed [32:0]   count_product;
   logic                 fwd_sel;
   logic                 rev_sel;
   logic [15:0]          sel_period;

   // Divider step.
   logic [17:0]          div_diff;
   logic                 out_free;
   logic [31:0]          quo_ext;

   logic                 csr_write;

   // Configuration port: writes complete on the access phase, reads are immediate.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_paddr[3:2])
         REG_MIN_PERIOD:       csr_prdata = {16'd0, min_period_ff};
         REG_STALL_TICKS:      csr_prdata = {24'd0, stall_ticks_ff};
         REG_PERIOD_NUMERATOR: csr_prdata = {8'd0, period_numerator_ff};
         REG_COUNT_GAIN:       csr_prdata = {16'd0, count_gain_ff};
         default:              csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_period_ff       <= MIN_PERIOD_RST;
         stall_ticks_ff      <= STALL_TICKS_RST;
         period_numerator_ff <= PERIOD_NUMERATOR_RST;
         count_gain_ff       <= COUNT_GAIN_RST;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            REG_MIN_PERIOD:       min_period_ff       <= csr_pwdata[15:0];
            REG_STALL_TICKS:      stall_ticks_ff      <= csr_pwdata[7:0];
            REG_PERIOD_NUMERATOR: period_numerator_ff <= csr_pwdata[23:0];
            REG_COUNT_GAIN:       count_gain_ff       <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Tick decode: position delta, stall counting and method selection.
   assign ch_ext      = {3'd0, req_data.channel};
   assign ch_in_range = ch_ext < 5'(NUM_CHANNELS);
   assign ch_idx      = ch_ext[IDX_W-1:0];
   assign req_stall   = (state_ff != ST_IDLE);
   assign tick_take   = req_valid && !req_stall;
   assign tick_update = tick_take && ch_in_range;

   assign pos_delta = req_data.position - last_pos_ff[ch_idx];
   assign idle_inc  = idle_cnt_ff[ch_idx] + 8'd1;

   always_comb begin
      tick_clear  = 1'b0;
      idle_cnt_in = 8'd0;
      if (pos_delta == 16'd0) begin
         if (idle_inc == stall_ticks_ff) begin
            tick_clear = 1'b1;
         end else begin
            idle_cnt_in = idle_inc;
         end
      end
   end

   // The gain is below 2^16 and the delta within a signed 16-bit range, so the
   // product always fits in 32 signed bits and never needs saturation.
   assign count_product = $signed({1'b0, count_gain_ff}) * $signed(pos_delta);

   assign fwd_sel    = req_data.fwd_period >= min_period_ff;
   assign rev_sel    = req_data.rev_period >= min_period_ff;
   assign sel_period = fwd_sel ? req_data.fwd_period : req_data.rev_period;

   // Restoring divider step: shift in the next numerator bit, try the subtract.
   assign div_diff = {1'b0, rem_ff, num_ff[23]} - {2'd0, divisor_ff};
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign quo_ext  = {8'd0, num_ff};

   // Sequencer: next state, job registers and output register loads.
   always_comb begin
      state_in       = state_ff;
      div_cnt_in     = div_cnt_ff;
      num_in         = num_ff;
      rem_in         = rem_ff;
      divisor_in     = divisor_ff;
      neg_in         = neg_ff;
      use_div_in     = use_div_ff;
      count_speed_in = count_speed_ff;
      job_channel_in = job_channel_ff;
      job_clear_in   = job_clear_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (tick_update) begin
               job_channel_in = req_data.channel;
               job_clear_in   = tick_clear;
               divisor_in     = sel_period;
               neg_in         = !fwd_sel;
               num_in         = period_numerator_ff;
               rem_in         = 16'd0;
               div_cnt_in     = '0;
               // A zero period means the capture was cleared: speed reads zero.
               count_speed_in = (fwd_sel || rev_sel) ? 32'sd0 : count_product[31:0];
               use_div_in     = (fwd_sel || rev_sel) && (sel_period != 16'd0);
               state_in       = ((fwd_sel || rev_sel) && (sel_period != 16'd0)) ?
                                ST_DIVIDE : ST_WRITE;
            end
         end

         ST_DIVIDE: begin
            if (!div_diff[17]) begin
               rem_in = div_diff[15:0];
            end else begin
               rem_in = {rem_ff[14:0], num_ff[23]};
            end
            num_in     = {num_ff[22:0], !div_diff[17]};
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_WRITE;
            end
         end

         ST_WRITE: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.out_channel    = job_channel_ff;
               rsp_data_in.clear_captures = job_clear_ff;
               if (use_div_ff) begin
                  rsp_data_in.speed = neg_ff ? -$signed(quo_ext) : $signed(quo_ext);
               end else begin
                  rsp_data_in.speed = count_speed_ff;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Channel state, cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            last_pos_ff[i] <= 16'd0;
            idle_cnt_ff[i] <= 8'd0;
         end
      end else if (tick_update) begin
         last_pos_ff[ch_idx] <= req_data.position;
         idle_cnt_ff[ch_idx] <= idle_cnt_in;
      end
   end

   // Job and result payload.
   always_ff @(posedge clock) begin
      div_cnt_ff     <= div_cnt_in;
      num_ff         <= num_in;
      rem_ff         <= rem_in;
      divisor_ff     <= divisor_in;
      neg_ff         <= neg_in;
      use_div_ff     <= use_div_in;
      count_speed_ff <= count_speed_in;
      job_channel_ff <= job_channel_in;
      job_clear_ff   <= job_clear_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks on the sequencer.
   `ESE_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (state_ff == ST_IDLE && !rsp_valid_ff), "reset did not idle the sequencer")
   `ESE_ASSERT(a_take_leaves_idle, clock, reset, tick_update |=> (state_ff != ST_IDLE), "accepted tick did not start a job")
   `ESE_ASSERT(a_new_result_from_write, clock, reset, (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff == ST_WRITE), "result appeared outside the write state")
   `ESE_ASSERT(a_divide_nonzero, clock, reset, (state_ff == ST_DIVIDE) |-> (divisor_ff != 16'd0 && use_div_ff), "divider running on a zero divisor")
   `ESE_ASSERT(a_divide_exit, clock, reset, (state_ff == ST_DIVIDE && div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) |=> (state_ff == ST_WRITE), "divider overran its step count")

endmodule
